[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[src/rrqs_pkg.sv]
// ----------------------------------------------------------------------------
// rrqs_pkg
// Types and constants shared by the round-robin quantum scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rrqs_pkg;

   localparam int JOB_W  = 3;
   localparam int WORK_W = 16;

   localparam logic CMD_ARRIVE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic [WORK_W-1:0] QUANTUM_RESET = 16'd1;

   typedef struct packed {
      logic              command;
      logic [JOB_W-1:0]  job_id;
      logic [WORK_W-1:0] work_amount;
   } req_type;

   typedef struct packed {
      logic             served;
      logic [JOB_W-1:0] served_job;
      logic             job_finished;
      logic             slice_expired;
   } rsp_type;

   typedef struct packed {
      logic [JOB_W-1:0]  job;
      logic [WORK_W-1:0] work;
   } fifo_entry_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic pop_second;
   } fifo_ctl_type;

endpackage

`default_nettype wire

[src/rrqs_ready_fifo.sv]
// ----------------------------------------------------------------------------
// rrqs_ready_fifo
// Ready queue of (job, remaining work) entries. One push and up to two pops
// per cycle; the head and the entry behind it come from registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module rrqs_ready_fifo import rrqs_pkg::*; #(
   parameter  int DEPTH = 8,
   localparam int PW    = $clog2(DEPTH),
   localparam int CW    = $clog2(DEPTH + 1)
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire fifo_ctl_type   ctl,
   input  wire fifo_entry_type push_entry,
   output logic [CW-1:0]       count,
   output fifo_entry_type      head_entry,
   output fifo_entry_type      next_entry
);

   fifo_entry_type mem [DEPTH];

   logic [PW-1:0]  head_ff, head_in;
   logic [PW-1:0]  tail_ff, tail_in;
   logic [PW-1:0]  second_addr;
   logic [CW-1:0]  count_ff, count_in;
   logic           push_ok;
   fifo_entry_type rd0_ff, rd1_ff;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   always_comb begin
      push_ok  = ctl.push && (count_ff != CW'(DEPTH));
      tail_in  = push_ok ? ptr_inc(tail_ff) : tail_ff;
      if (ctl.pop_second) begin
         head_in = ptr_inc(ptr_inc(head_ff));
      end else if (ctl.pop) begin
         head_in = ptr_inc(head_ff);
      end else begin
         head_in = head_ff;
      end
      second_addr = ptr_inc(head_in);
      count_in = count_ff + CW'(push_ok) - CW'(ctl.pop) - CW'(ctl.pop_second);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // write-through so the read registers always mirror the two head slots
   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem[tail_ff] <= push_entry;
      end
      rd0_ff <= (push_ok && (tail_ff == head_in)) ? push_entry : mem[head_in];
      rd1_ff <= (push_ok && (tail_ff == second_addr)) ? push_entry : mem[second_addr];
   end

   assign count      = count_ff;
   assign head_entry = rd0_ff;
   assign next_entry = rd1_ff;

endmodule

`default_nettype wire

[src/round_robin_quantum_scheduler_core.sv]
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_core
// Time-sliced round-robin scheduler with a FIFO ready queue.
//
//   channel | ports                           | beat
//   --------+---------------------------------+-----------------------------
//   request | start, busy, req_item           | start && !busy
//   result  | rsp_strobe, rsp_item            | rsp_strobe, one cycle, no stall
//   config  | csr_write_enable, csr_write_data| csr_write_enable
//
// One beat per cycle; busy is never raised, and the receiver cannot stall.
// A tick's result is strobed from the result register: the beat is
// registered, then one pass through the step logic fills the result
// register. Arrivals give no result. The queue head and the entry behind
// it sit in read registers, so back-to-back beats never wait.
// Synchronous reset clears all jobs, the queue and sets quantum to 1.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module round_robin_quantum_scheduler_core import rrqs_pkg::*; #(
   parameter int NUM_JOBS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire req_type           req_item,
   output logic                   rsp_strobe,
   output rsp_type                rsp_item,
   input  wire logic              csr_write_enable,
   input  wire logic [WORK_W-1:0] csr_write_data
);

   localparam int IDXW = $clog2(NUM_JOBS);
   localparam int CW   = $clog2(NUM_JOBS + 1);

   logic                item_valid_ff;
   req_type             item_ff;
   logic [WORK_W-1:0]   quantum_ff;

   logic [NUM_JOBS-1:0] busy_ff, busy_in;
   logic [JOB_W-1:0]    cur_job_ff, cur_job_in;
   logic                cur_valid_ff, cur_valid_in;
   logic [WORK_W-1:0]   cur_work_ff, cur_work_in;
   logic [WORK_W-1:0]   slice_ff, slice_in;
   logic                pending_ff, pending_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   rsp_type             rsp_ff, rsp_in;

   fifo_ctl_type        fifo_ctl;
   fifo_entry_type      push_entry;
   fifo_entry_type      head_entry;
   fifo_entry_type      next_entry;
   logic [CW-1:0]       fifo_count;

   logic                tick;
   logic                arrive;
   logic                in_range;
   logic [IDXW-1:0]     job_idx;
   logic [WORK_W-1:0]   full_slice;

   rrqs_ready_fifo #(
      .DEPTH(NUM_JOBS)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .ctl        (fifo_ctl),
      .push_entry (push_entry),
      .count      (fifo_count),
      .head_entry (head_entry),
      .next_entry (next_entry)
   );

   assign busy       = 1'b0;
   assign tick       = item_valid_ff && (item_ff.command == CMD_TICK);
   assign arrive     = item_valid_ff && (item_ff.command == CMD_ARRIVE);
   assign in_range   = (32'(item_ff.job_id) < NUM_JOBS);
   assign job_idx    = IDXW'(item_ff.job_id);
   assign full_slice = (quantum_ff == '0) ? WORK_W'(1) : quantum_ff;

   always_comb begin
      logic first_pop;
      logic [WORK_W-1:0] work_dec;
      logic [WORK_W-1:0] slice_dec;
      busy_in       = busy_ff;
      cur_job_in    = cur_job_ff;
      cur_valid_in  = cur_valid_ff;
      cur_work_in   = cur_work_ff;
      slice_in      = slice_ff;
      pending_in    = pending_ff;
      rsp_in        = '0;
      rsp_strobe_in = tick;
      fifo_ctl      = '0;
      push_entry    = '{job: cur_job_ff, work: cur_work_ff};
      first_pop     = 1'b0;
      work_dec      = '0;
      slice_dec     = '0;
      if (arrive) begin
         if (in_range && (item_ff.work_amount != '0) && !busy_ff[job_idx]) begin
            busy_in[job_idx] = 1'b1;
            if (!cur_valid_ff) begin
               cur_job_in   = item_ff.job_id;
               cur_work_in  = item_ff.work_amount;
               cur_valid_in = 1'b1;
               slice_in     = full_slice;
               pending_in   = 1'b0;
            end else begin
               fifo_ctl.push = 1'b1;
               push_entry    = '{job: item_ff.job_id, work: item_ff.work_amount};
            end
         end
      end else if (tick) begin
         pending_in = 1'b0;
         // preempted job goes behind the queue; a lone job simply restarts
         if (pending_ff && cur_valid_ff) begin
            slice_in = full_slice;
            if (fifo_count != '0) begin
               fifo_ctl.push = 1'b1;
               fifo_ctl.pop  = 1'b1;
               first_pop     = 1'b1;
               cur_job_in    = head_entry.job;
               cur_work_in   = head_entry.work;
            end
         end
         if (cur_valid_ff) begin
            work_dec  = (cur_work_in != '0) ? cur_work_in - WORK_W'(1) : cur_work_in;
            slice_dec = (slice_in != '0) ? slice_in - WORK_W'(1) : slice_in;
            rsp_in.served     = 1'b1;
            rsp_in.served_job = cur_job_in;
            cur_work_in       = work_dec;
            slice_in          = slice_dec;
            if (work_dec == '0) begin
               rsp_in.job_finished = 1'b1;
               busy_in[IDXW'(cur_job_in)] = 1'b0;
               if (first_pop) begin
                  fifo_ctl.pop_second = 1'b1;
                  slice_in            = full_slice;
                  if (fifo_count == CW'(1)) begin
                     cur_job_in  = cur_job_ff;
                     cur_work_in = cur_work_ff;
                  end else begin
                     cur_job_in  = next_entry.job;
                     cur_work_in = next_entry.work;
                  end
               end else if (fifo_count != '0) begin
                  fifo_ctl.pop = 1'b1;
                  slice_in     = full_slice;
                  cur_job_in   = head_entry.job;
                  cur_work_in  = head_entry.work;
               end else begin
                  cur_valid_in = 1'b0;
                  slice_in     = '0;
               end
            end else if (slice_dec == '0) begin
               rsp_in.slice_expired = 1'b1;
               pending_in           = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         quantum_ff    <= QUANTUM_RESET;
         busy_ff       <= '0;
         cur_job_ff    <= '0;
         cur_valid_ff  <= 1'b0;
         cur_work_ff   <= '0;
         slice_ff      <= '0;
         pending_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         item_valid_ff <= start && !busy;
         if (csr_write_enable) begin
            quantum_ff <= csr_write_data;
         end
         busy_ff       <= busy_in;
         cur_job_ff    <= cur_job_in;
         cur_valid_ff  <= cur_valid_in;
         cur_work_ff   <= cur_work_in;
         slice_ff      <= slice_in;
         pending_ff    <= pending_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= req_item;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   `ASSERT_NEXT(a_tick_gives_result, clock, reset, tick, rsp_strobe)
   `ASSERT_IMPLY(a_result_from_tick, clock, reset, rsp_strobe, $past(tick))
   `ASSERT_IMPLY(a_current_is_busy, clock, reset, cur_valid_ff, busy_ff[IDXW'(cur_job_ff)])
   `ASSERT_IMPLY(a_finish_excludes_expiry, clock, reset, rsp_strobe && rsp_item.job_finished, !rsp_item.slice_expired)
   `ASSERT_IMPLY(a_queue_bound, clock, reset, 1'b1, 32'(fifo_count) <= NUM_JOBS)

endmodule

`default_nettype wire
